// ===== rtl/afd_pkg.sv =====
// afd_pkg: shared types and constants for the adc frame deframer
// no dependencies; imported by afd_frame_fsm, adc_frame_deframer_core and the testbench
package afd_pkg;

	localparam int WORD_W   = 32;
	localparam int SAMPLE_W = 24;
	localparam int CHAN_W   = 8;
	localparam int SIZE_W   = 12;
	localparam int COUNT_W  = 10;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] SYNC_WORD = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 1'b1;

	localparam logic [CHAN_W-1:0] CHANNEL_ID_RST = 8'hEA;
	localparam logic [SIZE_W-1:0] MAX_FRAME_RST  = 12'd1500;

	typedef struct packed {
		logic                       hit;
		logic signed [SAMPLE_W-1:0] sample;
	} afd_result_t;

endpackage

// ===== rtl/afd_frame_fsm.sv =====
// afd_frame_fsm: sync hunt, header and size checks, payload word count
// depends on afd_pkg; gives the sample decoded from the word being stepped
module afd_frame_fsm #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [afd_pkg::WORD_W-1:0]    word,
	input  logic [afd_pkg::CHAN_W-1:0]    channel_id,
	input  logic [afd_pkg::SIZE_W-1:0]    max_frame_bytes,
	output afd_pkg::afd_result_t          result
);
	import afd_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_SIZE,
		PH_PAYLOAD
	} phase_t;

	phase_t               phase_q;
	logic [COUNT_W-1:0]   words_left_q;
	logic                 too_big;
	logic [COUNT_W-1:0]   size_words;
	logic [COUNT_W-1:0]   left_next;
	logic signed [SAMPLE_BITS-1:0] low_bits;

	assign too_big    = word > {{(WORD_W-SIZE_W){1'b0}}, max_frame_bytes};
	assign size_words = word[COUNT_W+1:2];
	assign left_next  = words_left_q - 1'b1;
	assign low_bits   = word[SAMPLE_BITS-1:0];

	always_comb begin
		result.hit    = (phase_q == PH_PAYLOAD) && (word[WORD_W-1 -: CHAN_W] == channel_id);
		result.sample = SAMPLE_W'(low_bits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			words_left_q <= '0;
		end else if (step) begin
			case (phase_q)
				PH_HUNT: begin
					if (word == SYNC_WORD) phase_q <= PH_HEADER;
				end
				PH_HEADER: begin
					phase_q <= word[WORD_W-1] ? PH_HUNT : PH_SIZE;
				end
				PH_SIZE: begin
					if (too_big) begin
						phase_q <= PH_HUNT;
					end else begin
						words_left_q <= size_words;
						phase_q      <= (size_words == '0) ? PH_HUNT : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					words_left_q <= left_next;
					if (left_next == '0) phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> words_left_q != '0)
		else $error("payload phase with no words left");
	a_hit_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result.hit |-> phase_q == PH_PAYLOAD)
		else $error("sample outside payload");
	a_oversize_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_SIZE && too_big |=> phase_q == PH_HUNT)
		else $error("oversized frame not dropped");
`endif

endmodule

// ===== rtl/adc_frame_deframer_core.sv =====
// adc_frame_deframer_core: top level of the adc frame deframer
// a hit sample is registered in the output register, or in the skid register on a stall
// throughput: one word per cycle while in_stall is low
// output register and skid register hold two samples; input stalls only while both are full
// reset: asynchronous, active low; hunting for sync, config registers to their defaults, output and skid empty
// depends on afd_pkg and afd_frame_fsm
module adc_frame_deframer_core #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [afd_pkg::WORD_W-1:0]           stream_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [afd_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 cfg_we,
	input  logic [afd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [afd_pkg::CFG_W-1:0]            cfg_data
);
	import afd_pkg::*;

	logic [CHAN_W-1:0]          channel_id_q;
	logic [SIZE_W-1:0]          max_frame_bytes_q;
	logic                       in_take;
	logic                       out_take;
	afd_result_t                res;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;
	logic                       skid_valid_q;
	logic signed [SAMPLE_W-1:0] skid_data_q;

	assign in_stall  = skid_valid_q;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign sample    = out_data_q;

	afd_frame_fsm #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_fsm (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (in_take),
		.word            (stream_word),
		.channel_id      (channel_id_q),
		.max_frame_bytes (max_frame_bytes_q),
		.result          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q      <= CHANNEL_ID_RST;
			max_frame_bytes_q <= MAX_FRAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_ID: channel_id_q      <= cfg_data[CHAN_W-1:0];
				CFG_MAX_FRAME:  max_frame_bytes_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// output sample register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (in_take && res.hit) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) out_data_q <= skid_data_q;
		end else if (in_take && res.hit) begin
			if (!out_valid_q || out_take) begin
				out_data_q <= res.sample;
			end else begin
				skid_data_q <= res.sample;
			end
		end
	end

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word while output is empty");
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_stall |=> skid_valid_q && $stable(skid_data_q))
		else $error("skid word lost during stall");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> out_valid_q && !skid_valid_q)
		else $error("skid word not moved to output");
`endif

endmodule

// ===== dv/adc_frame_deframer_core_tb.sv =====
// adc_frame_deframer_core_tb: self-checking testbench for the adc frame deframer
// predicts each sample from the words accepted and checks it against the output
// depends on afd_pkg and adc_frame_deframer_core
`timescale 1ns / 100ps

module adc_frame_deframer_core_tb;
	import afd_pkg::*;

	localparam int SMP_BITS    = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 2000;

	typedef enum logic [1:0] {ST_HUNT, ST_HDR, ST_LEN, ST_DATA} fr_phase_e;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic [WORD_W-1:0]          stream_word = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index   = CFG_CHANNEL_ID;
	logic [CFG_W-1:0]           cfg_data    = '0;

	// own copy of the deframer state and registers
	fr_phase_e                  fr_phase;
	logic [COUNT_W-1:0]         fr_left;
	logic [CHAN_W-1:0]          chan_sel;
	logic [SIZE_W-1:0]          frame_limit;
	logic signed [SAMPLE_W-1:0] sample_q[$];
	logic signed [SAMPLE_W-1:0] want;

	int errors      = 0;
	int stuck       = 0;
	int frame_words = 0;
	int hold_left   = 0;
	bit hold_req    = 1'b0;
	bit quiet       = 1'b0;

	adc_frame_deframer_core #(
		.SAMPLE_BITS(SMP_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.stream_word(stream_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] m;
		logic [WORD_W-1:0] v;
		m = (WORD_W'(1) << SMP_BITS) - 1'b1;
		v = w & m;
		if (v[SMP_BITS-1]) v = v | ~m;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic void deframe_word(input logic [WORD_W-1:0] w);
		case (fr_phase)
			ST_HUNT: begin
				if (w == SYNC_WORD) fr_phase = ST_HDR;
			end
			ST_HDR: begin
				if (w[WORD_W-1]) fr_phase = ST_HUNT;
				else fr_phase = ST_LEN;
			end
			ST_LEN: begin
				if (w > WORD_W'(frame_limit)) begin
					fr_phase = ST_HUNT;
				end else begin
					fr_left = w[COUNT_W+1:2];
					if (w[COUNT_W+1:2] == '0) fr_phase = ST_HUNT;
					else fr_phase = ST_DATA;
				end
			end
			default: begin
				if (w[WORD_W-1:WORD_W-CHAN_W] == chan_sel) sample_q.push_back(to_sample(w));
				fr_left = fr_left - 1'b1;
				if (fr_left == '0) fr_phase = ST_HUNT;
			end
		endcase
	endfunction

	// results leave first, then the word and register write of this edge are applied
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_phase    = ST_HUNT;
			fr_left     = '0;
			chan_sel    = CHANNEL_ID_RST;
			frame_limit = MAX_FRAME_RST;
			sample_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (sample_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected sample, expected none, actual %0d", $time, sample);
				end else begin
					want = sample_q.pop_front();
					if (sample !== want) begin
						errors++;
						$display("%0t: sample mismatch, expected %0d, actual %0d",
							$time, want, sample);
					end
				end
			end
			if (in_valid && !in_stall) deframe_word(stream_word);
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNEL_ID: chan_sel = cfg_data[CHAN_W-1:0];
					CFG_MAX_FRAME:  frame_limit = cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, stuck);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls (none while quiet), or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (quiet) begin
			out_stall = 1'b0;
		end else begin
			out_stall = ($urandom_range(0, 99) < 20);
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		stream_word = w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_frame(input logic [WORD_W-1:0] hdr, input logic [WORD_W-1:0] len_b,
			input int match_pct, input int cut);
		int n;
		logic [WORD_W-1:0] w;
		send_word(SYNC_WORD);
		send_word(hdr);
		frame_words += 2;
		if (hdr[WORD_W-1]) return;
		send_word(len_b);
		frame_words++;
		if (len_b > WORD_W'(frame_limit)) return;
		n = int'(len_b[COUNT_W+1:2]) - cut;
		for (int i = 0; i < n; i++) begin
			w = $urandom();
			if ($urandom_range(0, 99) < match_pct) w[WORD_W-1:WORD_W-CHAN_W] = chan_sel;
			if ($urandom_range(0, 49) == 0) w = SYNC_WORD;
			send_word(w);
			frame_words++;
		end
	endtask

	// lower valid, wait for every sample and for the pipe to empty
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sample_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		settle();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_default_frames();
		send_word(SYNC_WORD);
		send_word(32'h0000_0000);
		send_word(32'd16);
		send_word({CHANNEL_ID_RST, 24'h80_0000});
		send_word({CHANNEL_ID_RST, 24'h7F_FFFF});
		send_word(32'hEB12_3456);
		send_word({CHANNEL_ID_RST, 24'hFF_FFFF});
		// header with top bit set, then sync standing as header
		send_word(SYNC_WORD);
		send_word(32'h8000_0000);
		send_word({CHANNEL_ID_RST, 24'h00_0001});
		send_word(SYNC_WORD);
		send_word(SYNC_WORD);
		send_word(32'h0000_0000);
	endtask

	task automatic test_special_cases();
		write_reg(CFG_CHANNEL_ID, 12'hFFF);
		write_reg(CFG_MAX_FRAME, 12'hFFF);
		// sync word inside payload, odd size drops the remainder
		send_word(SYNC_WORD);
		send_word(32'h7FFF_FFFF);
		send_word(32'd7);
		send_word(SYNC_WORD);
		// oversized frames go straight back to hunting
		send_word(SYNC_WORD);
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(SYNC_WORD);
		send_word(32'h0000_0000);
		send_word(32'h0000_1000);
		// empty frame
		send_word(SYNC_WORD);
		send_word(32'h0000_0000);
		send_word(32'd3);
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_CHANNEL_ID, 12'hF00);
		write_reg(CFG_MAX_FRAME, 12'd0);
		send_frame(32'h0, 32'd0, 100, 0);
		send_frame(32'h0, 32'd1, 100, 0);
		write_reg(CFG_MAX_FRAME, 12'd4);
		send_frame(32'h0, 32'd4, 100, 0);
		write_reg(CFG_CHANNEL_ID, {4'h5, CHANNEL_ID_RST});
		write_reg(CFG_MAX_FRAME, MAX_FRAME_RST);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		send_frame(32'h0, 32'd160, 100, 0);
	endtask

	task automatic test_random();
		int pick;
		int cut;
		logic [WORD_W-1:0] hdr;
		logic [WORD_W-1:0] len_b;
		write_reg(CFG_MAX_FRAME, 12'hFFF);
		quiet = 1'b1;
		send_frame(32'h0, 32'd400, 50, 0);
		frame_words = 0;
		while (frame_words < 350) begin
			if (frame_words > 150) quiet = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				if ($urandom_range(0, 1)) write_reg(CFG_CHANNEL_ID, CFG_W'($urandom()));
				else if ($urandom_range(0, 3) == 0) write_reg(CFG_MAX_FRAME, CFG_W'($urandom()));
				else write_reg(CFG_MAX_FRAME, CFG_W'($urandom_range(64, 4095)));
			end else if (pick < 12) begin
				send_word($urandom());
			end else begin
				hdr = $urandom();
				hdr[WORD_W-1] = ($urandom_range(0, 9) == 0);
				case ($urandom_range(0, 9))
					0: len_b = $urandom();
					1: len_b = WORD_W'(frame_limit) + 1 + $urandom_range(0, 8);
					2: len_b = $urandom_range(0, 3);
					3: len_b = (frame_limit < 128) ? WORD_W'(frame_limit) : $urandom_range(4, 96);
					default: len_b = $urandom_range(4, 96);
				endcase
				cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
				send_frame(hdr, len_b, 60, cut);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_frames();
		test_special_cases();
		test_config_extremes();
		test_backpressure();
		test_random();
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0 && sample_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/afd_pkg.sv
rtl/afd_frame_fsm.sv
rtl/adc_frame_deframer_core.sv
dv/adc_frame_deframer_core_tb.sv
